FILE: rtl/elha_pkg.sv
package elha_pkg;

    // Word and field widths.
    localparam int WORD_W      = 32;
    localparam int KIND_W      = 1;
    localparam int REQ_SIZE_W  = 16;
    localparam int ADDR_W      = 14;
    localparam int STATUS_W    = 2;
    localparam int MAX_TRIES_W = 10;
    localparam int CHUNK_W     = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;

    typedef logic [WORD_W-1:0] word_t;

    // Default store depth in words (a power of two).
    localparam int HEAP_WORDS_DEF = 4096;

    // Register reset values.
    localparam logic [MAX_TRIES_W-1:0] MAX_TRIES_RST = 10'd500;
    localparam logic [CHUNK_W-1:0]     CHUNK_RST     = 13'd256;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = 1'd1;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ZERO    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOMEM   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd3;

    // Heap layout constants, byte offsets.
    localparam word_t WORD_BYTES    = 32'd4;
    localparam word_t DWORD_BYTES   = 32'd8;
    localparam word_t MIN_BLOCK     = 32'd16;
    localparam word_t LIST_TAIL     = 32'd8;
    localparam word_t LIST_HEAD     = 32'd24;
    localparam word_t FIRST_PAYLOAD = 32'd40;
    localparam word_t RESET_END     = 32'd64;

    // Word held by the store after reset, by word index.
    function automatic word_t init_word(input word_t idx);
        word_t v;
        v = '0;
        case (idx)
            32'd1, 32'd4, 32'd5, 32'd8: v = 32'd17;
            32'd2, 32'd7:               v = FIRST_PAYLOAD;
            32'd9, 32'd10, 32'd14:      v = 32'd24;
            32'd11:                     v = LIST_TAIL;
            32'd15:                     v = 32'd1;
            default:                    v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/elha_req_if.sv
interface elha_req_if import elha_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [REQ_SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0]     block_addr;

    modport source (output valid, kind, req_size, block_addr, input ready);
    modport sink (input valid, kind, req_size, block_addr, output ready);
endinterface

FILE: rtl/elha_rsp_if.sv
interface elha_rsp_if import elha_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   result_addr;
    logic [STATUS_W-1:0] status;

    modport source (output valid, result_addr, status, input ready);
    modport sink (input valid, result_addr, status, output ready);
endinterface

FILE: rtl/explicit_list_heap_allocator_core.sv
// Heap allocator with boundary tags and a LIFO doubly linked free list.
// Requests arrive on req (kind, req_size, block_addr) and each one gives
// exactly one item on rsp (result_addr, status). An allocate request walks
// the free list for an exact or the smallest larger block, grows the heap
// end if nothing fits, then places and splits the block. A free request
// checks the header and coalesces with both neighbours.
// All heap state lives in one single-port store with registered read
// data; every read and write goes through that port, one per cycle.
// An allocate walks at most max_tries+1 list entries in its search, then
// places and splits the block, first growing the heap end when nothing
// fits (or answering with no memory when the store is full); a free
// checks the header and stops early when it is not an allocated tag;
// a zero-size request or a rejected free address answers in the
// cycle after acceptance. The next request is taken once the sequencer is
// idle and the output register is free or being emptied.
// After reset the store is initialised by a pass over all HEAP_WORDS words,
// during which req.ready stays low; configuration writes are taken as ever.
// A stalled receiver holds the result in the output register and the
// block waits for it before it accepts another request.
module explicit_list_heap_allocator_core import elha_pkg::*; #(
    parameter int HEAP_WORDS = HEAP_WORDS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    elha_req_if.sink              req,
    elha_rsp_if.source            rsp
);

    localparam int    IW         = $clog2(HEAP_WORDS);
    localparam int    HEW        = IW + 3;
    localparam word_t HEAP_BYTES = word_t'(HEAP_WORDS) << 2;
    localparam int    SW         = 6;

    // Sequencer states.
    localparam logic [SW-1:0] S_CLEAR   = 6'd0;
    localparam logic [SW-1:0] S_IDLE    = 6'd1;
    localparam logic [SW-1:0] S_FIN     = 6'd2;
    localparam logic [SW-1:0] S_HEAD    = 6'd3;
    localparam logic [SW-1:0] S_LOOP    = 6'd4;
    localparam logic [SW-1:0] S_SZ      = 6'd5;
    localparam logic [SW-1:0] G_START   = 6'd6;
    localparam logic [SW-1:0] G_EPI     = 6'd7;
    localparam logic [SW-1:0] G_MRG     = 6'd8;
    localparam logic [SW-1:0] C_START   = 6'd9;
    localparam logic [SW-1:0] C_SZ      = 6'd10;
    localparam logic [SW-1:0] C_SPLIT   = 6'd11;
    localparam logic [SW-1:0] C_REM     = 6'd12;
    localparam logic [SW-1:0] C_PUSH    = 6'd13;
    localparam logic [SW-1:0] C_MRG     = 6'd14;
    localparam logic [SW-1:0] F_CHK     = 6'd15;
    localparam logic [SW-1:0] F_HDR     = 6'd16;
    localparam logic [SW-1:0] F_PUSH    = 6'd17;
    localparam logic [SW-1:0] F_MRG     = 6'd18;
    localparam logic [SW-1:0] U0        = 6'd19;
    localparam logic [SW-1:0] U1        = 6'd20;
    localparam logic [SW-1:0] U2        = 6'd21;
    localparam logic [SW-1:0] U3        = 6'd22;
    localparam logic [SW-1:0] T0        = 6'd23;
    localparam logic [SW-1:0] T1        = 6'd24;
    localparam logic [SW-1:0] P0        = 6'd25;
    localparam logic [SW-1:0] P1        = 6'd26;
    localparam logic [SW-1:0] P2        = 6'd27;
    localparam logic [SW-1:0] P3        = 6'd28;
    localparam logic [SW-1:0] P4        = 6'd29;
    localparam logic [SW-1:0] M0        = 6'd30;
    localparam logic [SW-1:0] M1        = 6'd31;
    localparam logic [SW-1:0] M2        = 6'd32;
    localparam logic [SW-1:0] M3        = 6'd33;
    localparam logic [SW-1:0] M_PA1     = 6'd34;
    localparam logic [SW-1:0] M_PA2     = 6'd35;
    localparam logic [SW-1:0] M_B1      = 6'd36;
    localparam logic [SW-1:0] M_B2      = 6'd37;
    localparam logic [SW-1:0] M_C1      = 6'd38;
    localparam logic [SW-1:0] M_C2      = 6'd39;
    localparam logic [SW-1:0] M_C3      = 6'd40;
    localparam logic [SW-1:0] M_C4      = 6'd41;
    localparam logic [SW-1:0] M_END     = 6'd42;

    logic [SW-1:0] state_reg, state_next;
    logic [SW-1:0] leaf_ret_reg, leaf_ret_next;
    logic [SW-1:0] merge_ret_reg, merge_ret_next;
    logic [IW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [HEW-1:0] heap_end_reg, heap_end_next;
    logic [MAX_TRIES_W-1:0] max_tries_reg;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [MAX_TRIES_W-1:0] tries_reg, tries_next;

    word_t asize_reg, asize_next;
    word_t cur_reg, cur_next;
    word_t best_reg, best_next;
    word_t best_size_reg, best_size_next;
    word_t bp_reg, bp_next;
    word_t res_reg, res_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    word_t csize_reg, csize_next;
    word_t gsize_reg, gsize_next;
    word_t l_bp_reg, l_bp_next;
    word_t l_size_reg, l_size_next;
    logic  l_alloc_reg, l_alloc_next;
    word_t l_p_reg, l_p_next;
    word_t l_n_reg, l_n_next;
    word_t m_bp_reg, m_bp_next;
    word_t m_size_reg, m_size_next;
    word_t m_nb_reg, m_nb_next;
    word_t m_pb_reg, m_pb_next;
    word_t m_pw_reg, m_pw_next;
    word_t m_t_reg, m_t_next;
    logic  m_na_reg, m_na_next;
    word_t m_res_reg, m_res_next;

    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    // Store port.
    word_t         mem [HEAP_WORDS];
    word_t         rd_data_reg;
    logic          mem_we;
    logic          mem_re;
    word_t         mem_addr;
    word_t         mem_wdata;
    logic [IW-1:0] mem_idx;

    logic  out_free;
    logic  accept;
    logic  free_bad;
    word_t sz_q;
    word_t ext;
    word_t words;
    word_t gsize_c;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_addr = out_addr_reg;
    assign rsp.status      = out_status_reg;

    assign sz_q = rd_data_reg & ~word_t'(7);

    assign mem_idx = (state_reg == S_CLEAR) ? clr_cnt_reg : mem_addr[IW+1:2];

    // Free address screening, done before any store access.
    assign free_bad = (req.block_addr == '0) || (req.block_addr[2:0] != 3'd0)
        || (word_t'(req.block_addr) < FIRST_PAYLOAD)
        || (word_t'(req.block_addr) >= word_t'(heap_end_reg));

    // Growth size: at least four words, rounded up to an even word count.
    always_comb
    begin
        ext   = (asize_reg > word_t'(chunk_reg)) ? asize_reg : word_t'(chunk_reg);
        words = ext >> 2;
        if (words < 32'd4)
        begin
            words = 32'd4;
        end
        if (words[0])
        begin
            words = words + 32'd1;
        end
        gsize_c = words << 2;
    end

    // Store: one synchronous port, read data registered.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_idx] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_idx];
        end
    end

    // Sequencer: each state issues at most one store access.
    always_comb
    begin
        state_next      = state_reg;
        leaf_ret_next   = leaf_ret_reg;
        merge_ret_next  = merge_ret_reg;
        clr_cnt_next    = clr_cnt_reg;
        heap_end_next   = heap_end_reg;
        tries_next      = tries_reg;
        asize_next      = asize_reg;
        cur_next        = cur_reg;
        best_next       = best_reg;
        best_size_next  = best_size_reg;
        bp_next         = bp_reg;
        res_next        = res_reg;
        st_next         = st_reg;
        csize_next      = csize_reg;
        gsize_next      = gsize_reg;
        l_bp_next       = l_bp_reg;
        l_size_next     = l_size_reg;
        l_alloc_next    = l_alloc_reg;
        l_p_next        = l_p_reg;
        l_n_next        = l_n_reg;
        m_bp_next       = m_bp_reg;
        m_size_next     = m_size_reg;
        m_nb_next       = m_nb_reg;
        m_pb_next       = m_pb_reg;
        m_pw_next       = m_pw_reg;
        m_t_next        = m_t_reg;
        m_na_next       = m_na_reg;
        m_res_next      = m_res_reg;
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = '0;
        mem_wdata       = '0;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = init_word(word_t'(clr_cnt_reg));
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {IW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    st_next  = STAT_DONE;
                    if (req.kind == KIND_ALLOC)
                    begin
                        if (req.req_size == '0)
                        begin
                            out_valid_next  = 1'b1;
                            out_addr_next   = '0;
                            out_status_next = STAT_ZERO;
                        end
                        else
                        begin
                            if (req.req_size <= REQ_SIZE_W'(8))
                            begin
                                asize_next = MIN_BLOCK;
                            end
                            else
                            begin
                                asize_next = (word_t'(req.req_size) + 32'd15) & ~word_t'(7);
                            end
                            state_next = S_HEAD;
                        end
                    end
                    else if (free_bad)
                    begin
                        out_valid_next  = 1'b1;
                        out_addr_next   = '0;
                        out_status_next = STAT_INVALID;
                    end
                    else
                    begin
                        bp_next    = word_t'(req.block_addr);
                        state_next = F_CHK;
                    end
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_reg[ADDR_W-1:0];
                    out_status_next = st_reg;
                    state_next      = S_IDLE;
                end
            end

            // Best-fit search over the free list.
            S_HEAD:
            begin
                mem_re         = 1'b1;
                mem_addr       = LIST_HEAD + WORD_BYTES;
                best_next      = '0;
                best_size_next = '0;
                tries_next     = '0;
                state_next     = S_LOOP;
            end

            S_LOOP:
            begin
                cur_next = rd_data_reg;
                if (rd_data_reg == LIST_TAIL)
                begin
                    bp_next    = best_reg;
                    state_next = (best_reg == '0) ? G_START : C_START;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_addr   = rd_data_reg - WORD_BYTES;
                    state_next = S_SZ;
                end
            end

            S_SZ:
            begin
                if (sz_q == asize_reg)
                begin
                    bp_next    = cur_reg;
                    state_next = (cur_reg == '0) ? G_START : C_START;
                end
                else
                begin
                    if (sz_q > asize_reg && (best_reg == '0 || sz_q < best_size_reg))
                    begin
                        best_next      = cur_reg;
                        best_size_next = sz_q;
                    end
                    if (tries_reg >= max_tries_reg)
                    begin
                        if (sz_q > asize_reg && (best_reg == '0 || sz_q < best_size_reg))
                        begin
                            bp_next    = cur_reg;
                            state_next = (cur_reg == '0) ? G_START : C_START;
                        end
                        else
                        begin
                            bp_next    = best_reg;
                            state_next = (best_reg == '0) ? G_START : C_START;
                        end
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_addr   = cur_reg + WORD_BYTES;
                        tries_next = tries_reg + 1'b1;
                        state_next = S_LOOP;
                    end
                end
            end

            // Heap growth.
            G_START:
            begin
                if (word_t'(heap_end_reg) + gsize_c > HEAP_BYTES)
                begin
                    res_next   = '0;
                    st_next    = STAT_NOMEM;
                    state_next = S_FIN;
                end
                else
                begin
                    gsize_next    = gsize_c;
                    bp_next       = word_t'(heap_end_reg);
                    heap_end_next = heap_end_reg + gsize_c[HEW-1:0];
                    l_bp_next     = word_t'(heap_end_reg);
                    l_size_next   = gsize_c;
                    l_alloc_next  = 1'b0;
                    leaf_ret_next = G_EPI;
                    state_next    = T0;
                end
            end

            G_EPI:
            begin
                mem_we        = 1'b1;
                mem_addr      = bp_reg + gsize_reg - WORD_BYTES;
                mem_wdata     = 32'd1;
                l_bp_next     = bp_reg;
                leaf_ret_next = G_MRG;
                state_next    = P0;
            end

            G_MRG:
            begin
                m_bp_next      = bp_reg;
                merge_ret_next = C_START;
                state_next     = M0;
            end

            // Placement and split.
            C_START:
            begin
                res_next   = bp_reg;
                mem_re     = 1'b1;
                mem_addr   = bp_reg - WORD_BYTES;
                state_next = C_SZ;
            end

            C_SZ:
            begin
                csize_next    = sz_q;
                l_bp_next     = bp_reg;
                leaf_ret_next = C_SPLIT;
                state_next    = U0;
            end

            C_SPLIT:
            begin
                l_bp_next    = bp_reg;
                l_alloc_next = 1'b1;
                state_next   = T0;
                if (csize_reg >= asize_reg && csize_reg - asize_reg >= MIN_BLOCK)
                begin
                    l_size_next   = asize_reg;
                    leaf_ret_next = C_REM;
                end
                else
                begin
                    l_size_next   = csize_reg;
                    st_next       = STAT_DONE;
                    leaf_ret_next = S_FIN;
                end
            end

            C_REM:
            begin
                bp_next       = bp_reg + asize_reg;
                l_bp_next     = bp_reg + asize_reg;
                l_size_next   = csize_reg - asize_reg;
                l_alloc_next  = 1'b0;
                leaf_ret_next = C_PUSH;
                state_next    = T0;
            end

            C_PUSH:
            begin
                l_bp_next     = bp_reg;
                leaf_ret_next = C_MRG;
                state_next    = P0;
            end

            C_MRG:
            begin
                m_bp_next      = bp_reg;
                st_next        = STAT_DONE;
                merge_ret_next = S_FIN;
                state_next     = M0;
            end

            // Free: header check, retag, push and coalesce.
            F_CHK:
            begin
                mem_re     = 1'b1;
                mem_addr   = bp_reg - WORD_BYTES;
                state_next = F_HDR;
            end

            F_HDR:
            begin
                if (rd_data_reg[2:0] != 3'd1)
                begin
                    st_next    = STAT_INVALID;
                    state_next = S_FIN;
                end
                else
                begin
                    l_bp_next     = bp_reg;
                    l_size_next   = sz_q;
                    l_alloc_next  = 1'b0;
                    leaf_ret_next = F_PUSH;
                    state_next    = T0;
                end
            end

            F_PUSH:
            begin
                l_bp_next     = bp_reg;
                leaf_ret_next = F_MRG;
                state_next    = P0;
            end

            F_MRG:
            begin
                m_bp_next      = bp_reg;
                st_next        = STAT_DONE;
                merge_ret_next = S_FIN;
                state_next     = M0;
            end

            // Unlink l_bp from the free list.
            U0:
            begin
                mem_re     = 1'b1;
                mem_addr   = l_bp_reg;
                state_next = U1;
            end

            U1:
            begin
                l_p_next   = rd_data_reg;
                mem_re     = 1'b1;
                mem_addr   = l_bp_reg + WORD_BYTES;
                state_next = U2;
            end

            U2:
            begin
                l_n_next   = rd_data_reg;
                mem_we     = 1'b1;
                mem_addr   = l_p_reg + WORD_BYTES;
                mem_wdata  = rd_data_reg;
                state_next = U3;
            end

            U3:
            begin
                mem_we     = 1'b1;
                mem_addr   = l_n_reg;
                mem_wdata  = l_p_reg;
                state_next = leaf_ret_reg;
            end

            // Write header and footer tags.
            T0:
            begin
                mem_we     = 1'b1;
                mem_addr   = l_bp_reg - WORD_BYTES;
                mem_wdata  = l_size_reg | word_t'(l_alloc_reg);
                state_next = T1;
            end

            T1:
            begin
                mem_we     = 1'b1;
                mem_addr   = l_bp_reg + l_size_reg - DWORD_BYTES;
                mem_wdata  = l_size_reg | word_t'(l_alloc_reg);
                state_next = leaf_ret_reg;
            end

            // Push l_bp at the front of the free list.
            P0:
            begin
                mem_re     = 1'b1;
                mem_addr   = LIST_HEAD + WORD_BYTES;
                state_next = P1;
            end

            P1:
            begin
                l_n_next   = rd_data_reg;
                mem_we     = 1'b1;
                mem_addr   = l_bp_reg;
                mem_wdata  = LIST_HEAD;
                state_next = P2;
            end

            P2:
            begin
                mem_we     = 1'b1;
                mem_addr   = l_n_reg;
                mem_wdata  = l_bp_reg;
                state_next = P3;
            end

            P3:
            begin
                mem_we     = 1'b1;
                mem_addr   = l_bp_reg + WORD_BYTES;
                mem_wdata  = l_n_reg;
                state_next = P4;
            end

            P4:
            begin
                mem_we     = 1'b1;
                mem_addr   = LIST_HEAD + WORD_BYTES;
                mem_wdata  = l_bp_reg;
                state_next = leaf_ret_reg;
            end

            // Coalesce m_bp with its neighbours.
            M0:
            begin
                mem_re     = 1'b1;
                mem_addr   = m_bp_reg - WORD_BYTES;
                state_next = M1;
            end

            M1:
            begin
                m_size_next = sz_q;
                mem_re      = 1'b1;
                mem_addr    = m_bp_reg - DWORD_BYTES;
                state_next  = M2;
            end

            M2:
            begin
                m_pw_next  = rd_data_reg;
                m_nb_next  = m_bp_reg + m_size_reg;
                mem_re     = 1'b1;
                mem_addr   = m_bp_reg + m_size_reg - WORD_BYTES;
                state_next = M3;
            end

            M3:
            begin
                if (m_pw_reg[0] && rd_data_reg[0])
                begin
                    m_res_next = m_bp_reg;
                    state_next = M_END;
                end
                else if (m_pw_reg[0])
                begin
                    m_res_next    = m_bp_reg;
                    l_bp_next     = m_nb_reg;
                    leaf_ret_next = M_PA1;
                    state_next    = U0;
                end
                else
                begin
                    m_pb_next     = m_bp_reg - (m_pw_reg & ~word_t'(7));
                    m_res_next    = m_bp_reg - (m_pw_reg & ~word_t'(7));
                    m_na_next     = rd_data_reg[0];
                    l_bp_next     = m_bp_reg;
                    leaf_ret_next = M_B1;
                    state_next    = U0;
                end
            end

            M_PA1:
            begin
                mem_re     = 1'b1;
                mem_addr   = m_nb_reg - WORD_BYTES;
                state_next = M_PA2;
            end

            M_PA2:
            begin
                l_bp_next     = m_bp_reg;
                l_size_next   = m_size_reg + sz_q;
                l_alloc_next  = 1'b0;
                leaf_ret_next = M_END;
                state_next    = T0;
            end

            M_B1:
            begin
                if (m_na_reg)
                begin
                    mem_re     = 1'b1;
                    mem_addr   = m_pb_reg - WORD_BYTES;
                    state_next = M_B2;
                end
                else
                begin
                    l_bp_next     = m_nb_reg;
                    leaf_ret_next = M_C1;
                    state_next    = U0;
                end
            end

            M_B2:
            begin
                l_bp_next     = m_pb_reg;
                l_size_next   = m_size_reg + sz_q;
                l_alloc_next  = 1'b0;
                leaf_ret_next = M_END;
                state_next    = T0;
            end

            M_C1:
            begin
                mem_re     = 1'b1;
                mem_addr   = m_pb_reg - WORD_BYTES;
                state_next = M_C2;
            end

            M_C2:
            begin
                m_t_next   = sz_q;
                mem_re     = 1'b1;
                mem_addr   = m_nb_reg - WORD_BYTES;
                state_next = M_C3;
            end

            M_C3:
            begin
                mem_re     = 1'b1;
                mem_addr   = m_nb_reg + sz_q - DWORD_BYTES;
                state_next = M_C4;
            end

            M_C4:
            begin
                l_bp_next     = m_pb_reg;
                l_size_next   = m_size_reg + m_t_reg + sz_q;
                l_alloc_next  = 1'b0;
                leaf_ret_next = M_END;
                state_next    = T0;
            end

            M_END:
            begin
                bp_next    = m_res_reg;
                state_next = merge_ret_reg;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            leaf_ret_reg   <= S_IDLE;
            merge_ret_reg  <= S_IDLE;
            clr_cnt_reg    <= '0;
            heap_end_reg   <= HEW'(RESET_END);
            max_tries_reg  <= MAX_TRIES_RST;
            chunk_reg      <= CHUNK_RST;
            tries_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            leaf_ret_reg   <= leaf_ret_next;
            merge_ret_reg  <= merge_ret_next;
            clr_cnt_reg    <= clr_cnt_next;
            heap_end_reg   <= heap_end_next;
            tries_reg      <= tries_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we && cfg_index == CFG_MAX_TRIES)
            begin
                max_tries_reg <= cfg_data[MAX_TRIES_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_CHUNK_BYTES)
            begin
                chunk_reg <= cfg_data[CHUNK_W-1:0];
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        asize_reg      <= asize_next;
        cur_reg        <= cur_next;
        best_reg       <= best_next;
        best_size_reg  <= best_size_next;
        bp_reg         <= bp_next;
        res_reg        <= res_next;
        st_reg         <= st_next;
        csize_reg      <= csize_next;
        gsize_reg      <= gsize_next;
        l_bp_reg       <= l_bp_next;
        l_size_reg     <= l_size_next;
        l_alloc_reg    <= l_alloc_next;
        l_p_reg        <= l_p_next;
        l_n_reg        <= l_n_next;
        m_bp_reg       <= m_bp_next;
        m_size_reg     <= m_size_next;
        m_nb_reg       <= m_nb_next;
        m_pb_reg       <= m_pb_next;
        m_pw_reg       <= m_pw_next;
        m_t_reg        <= m_t_next;
        m_na_reg       <= m_na_next;
        m_res_reg      <= m_res_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    // The heap end stays inside the store and on a double-word boundary.
    a_heap_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
        word_t'(heap_end_reg) <= HEAP_BYTES && heap_end_reg[2:0] == 3'd0)
        else $error("heap end out of range or misaligned");

    // A free of the null address is answered in the next cycle as invalid.
    a_null_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.kind == KIND_FREE && req.block_addr == '0
        |=> rsp.valid && rsp.status == STAT_INVALID)
        else $error("null free not rejected at once");

    // The search never walks past its entry limit.
    a_tries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SZ |-> tries_reg <= max_tries_reg)
        else $error("free-list search passed its limit");

endmodule

FILE: verif/tb_explicit_list_heap_allocator_core.sv
`timescale 1ns / 100ps

module tb_explicit_list_heap_allocator_core;
    import elha_pkg::*;

    localparam int    STORE_WORDS = HEAP_WORDS_DEF;
    localparam word_t STORE_BYTES = word_t'(STORE_WORDS) * 32'd4;
    localparam word_t TAG_MASK    = 32'hFFFF_FFF8;
    localparam int    STALL_LIMIT = 30000;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [ADDR_W-1:0]   result_addr;
        logic [STATUS_W-1:0] status;
    } alloc_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    elha_req_if req_ch ();
    elha_rsp_if rsp_ch ();

    explicit_list_heap_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Shadow copy of the heap and the allocator registers.
    word_t heap_mem [0:STORE_WORDS-1];
    word_t heap_top;
    word_t tries_cfg;
    word_t chunk_cfg;

    alloc_result_t results_due [$];
    word_t         live_blocks [$];
    int            mismatches  = 0;
    bit            no_idle     = 0;
    int            hold_len    = 0;
    int            hold_cnt    = 0;
    int            idle_cycles = 0;

    function automatic word_t hp_rd(word_t a);
        return heap_mem[a[13:2]];
    endfunction

    function automatic void hp_wr(word_t a, word_t v);
        heap_mem[a[13:2]] = v;
    endfunction

    function automatic word_t blk_sz(word_t bp);
        return hp_rd(bp - 4) & TAG_MASK;
    endfunction

    function automatic void put_tags(word_t bp, word_t sz, word_t alloc);
        hp_wr(bp - 4, sz | alloc);
        hp_wr(bp + sz - 8, sz | alloc);
    endfunction

    function automatic void unlink(word_t bp);
        word_t p, n;
        p = hp_rd(bp);
        n = hp_rd(bp + 4);
        hp_wr(p + 4, n);
        hp_wr(n, p);
    endfunction

    function automatic void push_front(word_t bp);
        word_t first;
        first = hp_rd(LIST_HEAD + 4);
        hp_wr(bp, LIST_HEAD);
        hp_wr(first, bp);
        hp_wr(bp + 4, first);
        hp_wr(LIST_HEAD + 4, bp);
    endfunction

    // Joins a free block with whichever neighbours are free.
    function automatic word_t coalesce(word_t bp);
        word_t sz, pa, na, nb, pb;
        sz = blk_sz(bp);
        pa = hp_rd(bp - 8) & 1;
        nb = bp + sz;
        na = hp_rd(nb - 4) & 1;
        if (pa != 0 && na != 0)
            return bp;
        if (pa != 0)
        begin
            unlink(nb);
            sz += blk_sz(nb);
            put_tags(bp, sz, 0);
            return bp;
        end
        pb = bp - (hp_rd(bp - 8) & TAG_MASK);
        unlink(bp);
        if (na != 0)
            sz += blk_sz(pb);
        else
        begin
            unlink(nb);
            sz += blk_sz(pb) + (hp_rd(nb + blk_sz(nb) - 8) & TAG_MASK);
        end
        put_tags(pb, sz, 0);
        return pb;
    endfunction

    // Best fit over the free list, cut short after tries_cfg+1 entries.
    function automatic word_t best_fit(word_t asize);
        word_t cur, best, best_sz, tries, sz;
        cur = hp_rd(LIST_HEAD + 4);
        best = 0;
        best_sz = 0;
        tries = 0;
        while (cur != LIST_TAIL)
        begin
            sz = blk_sz(cur);
            if (sz == asize)
                return cur;
            if (sz > asize && (best == 0 || sz < best_sz))
            begin
                best = cur;
                best_sz = sz;
            end
            if (tries >= tries_cfg)
                return best;
            cur = hp_rd(cur + 4);
            tries++;
        end
        return best;
    endfunction

    function automatic void place(word_t bp, word_t asize);
        word_t csize, rb, dummy;
        csize = blk_sz(bp);
        unlink(bp);
        if (csize >= asize && csize - asize >= MIN_BLOCK)
        begin
            put_tags(bp, asize, 1);
            rb = bp + asize;
            put_tags(rb, csize - asize, 0);
            push_front(rb);
            dummy = coalesce(rb);
        end
        else
            put_tags(bp, csize, 1);
    endfunction

    function automatic word_t extend(word_t bytes);
        word_t words, sz, bp;
        words = bytes / 4;
        if (words < 4)
            words = 4;
        if (words[0])
            words++;
        sz = words * 4;
        if (heap_top + sz > STORE_BYTES)
            return 0;
        bp = heap_top;
        heap_top += sz;
        put_tags(bp, sz, 0);
        hp_wr(bp + sz - 4, 1);
        push_front(bp);
        return coalesce(bp);
    endfunction

    function automatic void heap_reset();
        for (int i = 0; i < STORE_WORDS; i++)
            heap_mem[i] = '0;
        tries_cfg = word_t'(MAX_TRIES_RST);
        chunk_cfg = word_t'(CHUNK_RST);
        put_tags(LIST_TAIL, MIN_BLOCK, 1);
        put_tags(LIST_HEAD, MIN_BLOCK, 1);
        hp_wr(LIST_TAIL, FIRST_PAYLOAD);
        hp_wr(LIST_HEAD + 4, FIRST_PAYLOAD);
        put_tags(FIRST_PAYLOAD, 24, 0);
        hp_wr(FIRST_PAYLOAD, LIST_HEAD);
        hp_wr(FIRST_PAYLOAD + 4, LIST_TAIL);
        hp_wr(60, 1);
        heap_top = RESET_END;
    endfunction

    // Works out the result of one request and updates the shadow heap.
    function automatic alloc_result_t predict_request(logic [KIND_W-1:0] kind,
                                                      word_t req, word_t addr);
        alloc_result_t r;
        word_t asize, bp, dummy, hdr;
        r.kind = kind;
        r.result_addr = '0;
        r.status = STAT_DONE;
        hdr = hp_rd(addr - 4);
        if (kind == KIND_ALLOC)
        begin
            if (req == 0)
                r.status = STAT_ZERO;
            else
            begin
                asize = (req <= 8) ? MIN_BLOCK : 8 * ((req + 15) / 8);
                bp = best_fit(asize);
                if (bp == 0)
                    bp = extend((asize > chunk_cfg) ? asize : chunk_cfg);
                if (bp == 0)
                    r.status = STAT_NOMEM;
                else
                begin
                    place(bp, asize);
                    r.result_addr = bp[ADDR_W-1:0];
                    live_blocks.push_back(bp);
                end
            end
        end
        else if (addr == 0 || addr[2:0] != 0 || addr < FIRST_PAYLOAD || addr >= heap_top
                 || hdr[2:0] != 3'b001)
            r.status = STAT_INVALID;
        else
        begin
            put_tags(addr, blk_sz(addr), 0);
            push_front(addr);
            dummy = coalesce(addr);
        end
        return r;
    endfunction

    // Clock.
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    task automatic report(string what, int expd, int got);
        $display("ERROR %0t: %s expected %0d got %0d", $realtime, what, expd, got);
        mismatches++;
    endtask

    // Offers one item, with random gaps before it unless no_idle is set, and predicts its result.
    task automatic send_item(logic [KIND_W-1:0] kind, word_t req, word_t addr);
        if (!no_idle && $urandom_range(99) < 38)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 38);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= kind;
        req_ch.req_size   <= req[REQ_SIZE_W-1:0];
        req_ch.block_addr <= addr[ADDR_W-1:0];
        do
            @(posedge clk);
        while (!req_ch.ready);
        results_due.push_back(predict_request(kind, req, addr));
    endtask

    // Lets every outstanding result arrive, leaving the input idle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, word_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_TRIES)
            tries_cfg = val & 32'h3FF;
        else
            chunk_cfg = val & 32'h1FFF;
    endtask

    function automatic word_t pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return $urandom_range(64, 1);
        if (r < 85)
            return $urandom_range(512, 65);
        if (r < 97)
            return $urandom_range(3000, 513);
        return $urandom_range(65535);
    endfunction

    // Frees a live block when there is one, otherwise allocates.
    task automatic send_free_live();
        int k;
        if (live_blocks.size() == 0)
            send_item(KIND_ALLOC, pick_size(), $urandom_range(16383));
        else
        begin
            k = $urandom_range(live_blocks.size() - 1);
            send_item(KIND_FREE, $urandom_range(65535), live_blocks[k]);
            live_blocks.delete(k);
        end
    endtask

    // Edge sizes, every status and the rejected free addresses.
    task automatic test_directed();
        word_t a;
        send_item(KIND_ALLOC, 0, 16383);
        send_item(KIND_ALLOC, 1, 0);
        send_item(KIND_ALLOC, 8, 0);
        send_item(KIND_ALLOC, 9, 0);
        send_item(KIND_ALLOC, 24, 0);
        send_item(KIND_ALLOC, 65535, 0);
        send_item(KIND_FREE, 65535, 0);
        send_item(KIND_FREE, 0, 41);
        send_item(KIND_FREE, 0, 32);
        send_item(KIND_FREE, 0, 16376);
        send_item(KIND_FREE, 0, 16383);
        a = FIRST_PAYLOAD;
        send_item(KIND_FREE, 0, a);
        send_item(KIND_FREE, 0, a);
        send_item(KIND_ALLOC, 1, 0);
        // A free inside a live payload rather than at its start.
        send_item(KIND_ALLOC, 100, 0);
        if (live_blocks.size() != 0)
            send_item(KIND_FREE, 0, live_blocks[$] + 8);
        repeat (4) send_free_live();
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 5)
                send_item(KIND_W'($urandom_range(1)), pick_size(), $urandom_range(16383));
            else if ($urandom_range(99) < 42)
                send_free_live();
            else
                send_item(KIND_ALLOC, pick_size(), $urandom_range(16383));
        end
        drain();
    endtask

    // The receiver holds off while the sender keeps offering items.
    task automatic test_backpressure();
        no_idle = 1;
        hold_len <= 400;
        for (int i = 0; i < 30; i++)
            send_item(KIND_ALLOC, $urandom_range(64, 1), 0);
        no_idle = 0;
        drain();
    endtask

    task automatic test_settings();
        cfg_write(CFG_MAX_TRIES, 0);
        cfg_write(CFG_CHUNK_BYTES, 16);
        test_random(250);
        cfg_write(CFG_MAX_TRIES, 1023);
        cfg_write(CFG_CHUNK_BYTES, 4096);
        test_random(250);
        cfg_write(CFG_MAX_TRIES, 1);
        cfg_write(CFG_CHUNK_BYTES, 20);
        test_random(250);
        cfg_write(CFG_MAX_TRIES, $urandom_range(1023));
        cfg_write(CFG_CHUNK_BYTES, $urandom_range(4096, 16));
        test_random(250);
    endtask

    task automatic test_no_idle();
        no_idle = 1;
        test_random(250);
        no_idle = 0;
    endtask

    // Stimulus sequence.
    initial
    begin
        heap_reset();
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_MAX_TRIES;
        cfg_data     <= '0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= KIND_ALLOC;
        req_ch.req_size   <= '0;
        req_ch.block_addr <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(300);
        test_backpressure();
        test_settings();
        test_no_idle();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver stalls, with a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_len != 0)
        begin
            hold_cnt = hold_len;
            hold_len <= 0;
        end
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= 38);
    end

    // Compares each result item with the oldest prediction.
    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (results_due.size() == 0)
                report("unexpected result, addr", -1, rsp_ch.result_addr);
            else
            begin
                e = results_due.pop_front();
                if (rsp_ch.result_addr !== e.result_addr)
                    report("result_addr", e.result_addr, rsp_ch.result_addr);
                if (rsp_ch.status !== e.status)
                    report("status", e.status, rsp_ch.status);
            end
        end
    end

    // Ends the run when nothing has been accepted for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
